// ----- rtl/q2e_pkg.sv -----
package q2e_pkg;

  localparam int CompBits    = 16;
  localparam int AngleBits   = 16;
  localparam int CordicSteps = 16;
  localparam int TabLen      = 32;

  // Internal widths: products at 2^28 per unit, CORDIC operands scaled by a further 2^24.
  localparam int ProdW   = 32;
  localparam int OpW     = 36;
  localparam int PreSh   = 24;
  localparam int XyW     = 60;
  localparam int ZW      = 34;
  localparam int UsW     = 28;
  localparam int RemW    = 58;
  localparam int RootW   = 29;

  typedef struct packed {
    logic signed [CompBits-1:0] quat_x;
    logic signed [CompBits-1:0] quat_y;
    logic signed [CompBits-1:0] quat_z;
    logic signed [CompBits-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [AngleBits-1:0] pitch_angle;
    logic signed [AngleBits-1:0] yaw_angle;
    logic signed [AngleBits-1:0] roll_angle;
  } euler_t;

  typedef struct packed {
    logic signed [OpW-1:0] siny;
    logic signed [OpW-1:0] cosy;
    logic signed [OpW-1:0] sinr;
    logic signed [OpW-1:0] cosr;
    logic signed [OpW-1:0] sinp;
    logic                  psat;
  } side_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    side_t            side;
  } sqrt_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } lane_t;

  typedef struct packed {
    lane_t pitch;
    lane_t yaw;
    lane_t roll;
    logic  psat;
    logic  psign;
  } crd_t;

  localparam int ShR = (CompBits >= 16) ? CompBits - 16 : 0;
  localparam int ShL = (CompBits < 16) ? 16 - CompBits : 0;

  // Brings a component of any width to Q2.14.
  function automatic logic signed [15:0] load_comp(input logic signed [CompBits-1:0] v);
    logic signed [CompBits+15:0] w;
    w = (CompBits + 16)'(v);
    w = w <<< ShL;
    w = w >>> ShR;
    return w[15:0];
  endfunction

  // atan(2^-i) with pi equal to 2^31.
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = ZW'(536870912);
      1:  a = ZW'(316933406);
      2:  a = ZW'(167458907);
      3:  a = ZW'(85004756);
      4:  a = ZW'(42667331);
      5:  a = ZW'(21354465);
      6:  a = ZW'(10679838);
      7:  a = ZW'(5340245);
      8:  a = ZW'(2670163);
      9:  a = ZW'(1335087);
      10: a = ZW'(667544);
      11: a = ZW'(333772);
      12: a = ZW'(166886);
      13: a = ZW'(83443);
      14: a = ZW'(41722);
      15: a = ZW'(20861);
      16: a = ZW'(10430);
      17: a = ZW'(5215);
      18: a = ZW'(2608);
      19: a = ZW'(1304);
      20: a = ZW'(652);
      21: a = ZW'(326);
      22: a = ZW'(163);
      23: a = ZW'(81);
      24: a = ZW'(41);
      25: a = ZW'(20);
      26: a = ZW'(10);
      27: a = ZW'(5);
      28: a = ZW'(3);
      29: a = ZW'(1);
      30: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  localparam int AngSh = 32 - AngleBits;
  localparam logic signed [ZW:0] RndHalf = (AngSh > 0) ? ((ZW+1)'(1) <<< (AngSh - 1)) : '0;
  localparam logic signed [ZW:0] AngHi = ((ZW+1)'(1) <<< (AngleBits - 1)) - (ZW+1)'(1);
  localparam logic signed [ZW:0] AngLo = -AngHi - (ZW+1)'(1);

  // Rounds half up to the angle width and saturates.
  function automatic logic signed [AngleBits-1:0] to_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] r;
    r = ((ZW+1)'(z) + RndHalf) >>> AngSh;
    if (r > AngHi) r = AngHi;
    if (r < AngLo) r = AngLo;
    return r[AngleBits-1:0];
  endfunction

endpackage

// ----- rtl/q2e_sqrt_cell.sv -----
module q2e_sqrt_cell #(
  parameter int K = 0
) (
  input  logic          clk,
  input  logic          en,
  input  q2e_pkg::sqrt_t d,
  output q2e_pkg::sqrt_t q
);
  import q2e_pkg::*;

  logic [RemW+1:0] t;
  logic [RemW+1:0] remx;
  sqrt_t           nxt;

  // One root bit per cell: the trial term is (2r + 2^K) * 2^K.
  always_comb begin
    t    = ((RemW+2)'(d.root) << (K + 1)) + ((RemW+2)'(1) << (2 * K));
    remx = (RemW+2)'(d.rem);
    nxt  = d;
    if (remx >= t) begin
      nxt.rem  = RemW'(remx - t);
      nxt.root = d.root | (RootW'(1) << K);
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

// ----- rtl/q2e_cordic_cell.sv -----
module q2e_cordic_cell #(
  parameter int I = 0
) (
  input  logic         clk,
  input  logic         en,
  input  q2e_pkg::crd_t d,
  output q2e_pkg::crd_t q
);
  import q2e_pkg::*;

  crd_t nxt;

  function automatic lane_t rot(input lane_t a);
    lane_t r;
    r = a;
    if (a.y > 0) begin
      r.x = a.x + (a.y >>> I);
      r.y = a.y - (a.x >>> I);
      r.z = a.z + atan_val(I);
    end else if (a.y < 0) begin
      r.x = a.x - (a.y >>> I);
      r.y = a.y + (a.x >>> I);
      r.z = a.z - atan_val(I);
    end
    return r;
  endfunction

  always_comb begin
    nxt       = d;
    nxt.pitch = rot(d.pitch);
    nxt.yaw   = rot(d.yaw);
    nxt.roll  = rot(d.roll);
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

// ----- rtl/quaternion_to_euler.sv -----
// Quaternion to Z-Y-X Euler angles. One quaternion in Q2.14 is taken per beat and
// a new one may enter every cycle while quat_stall is low; it passes through the
// product and sum stages, a squaring stage, 29 square-root cells (one root bit each)
// for the pitch cosine, one quadrant stage, one CORDIC cell per step and the output
// register. Angles are binary: pi is 2^(angle width - 1), saturated at the top.
// A stage holds its beat while the next one holds, so bubbles close up under a stall.
module quaternion_to_euler #(
  parameter int CORDIC_STEPS = q2e_pkg::CordicSteps
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            quat_valid,
  output logic            quat_stall,
  input  q2e_pkg::quat_t  quat,
  output logic            euler_valid,
  input  logic            euler_stall,
  output q2e_pkg::euler_t euler
);
  import q2e_pkg::*;

  localparam int NSqrt = RootW;
  localparam int StPre = 3 + NSqrt;
  localparam int NSt   = StPre + CORDIC_STEPS + 2;
  localparam logic signed [OpW-1:0] OneQ28 = OpW'(1) <<< 28;
  localparam logic signed [ZW-1:0] QuarterZ = ZW'(1) <<< 30;
  localparam logic signed [AngleBits-1:0] PitchQ = AngleBits'(1) <<< (AngleBits - 2);

  logic [NSt-1:0] vld;
  logic [NSt:0]   go;

  assign go[NSt] = !euler_stall;
  genvar g;
  generate
    for (g = 0; g < NSt; g++) begin : g_go
      assign go[g] = !vld[g] || go[g+1];
    end
  endgenerate

  assign quat_stall  = !go[0];
  assign euler_valid = vld[NSt-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) vld[0] <= quat_valid;
      for (int i = 1; i < NSt; i++) begin
        if (go[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Products of the Q2.14 components.
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [ProdW-1:0] p_wz, p_xy, p_yy, p_zz, p_wy, p_zx, p_wx, p_yz, p_xx;

  always_comb begin
    qx = load_comp(quat.quat_x);
    qy = load_comp(quat.quat_y);
    qz = load_comp(quat.quat_z);
    qw = load_comp(quat.quat_w);
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
    end
  end

  side_t s1;
  always_ff @(posedge clk) begin
    if (go[1]) begin
      s1.siny <= (OpW'(p_wz) + OpW'(p_xy)) <<< 1;
      s1.cosy <= OneQ28 - ((OpW'(p_yy) + OpW'(p_zz)) <<< 1);
      s1.sinp <= (OpW'(p_wy) - OpW'(p_zx)) <<< 1;
      s1.sinr <= (OpW'(p_wx) + OpW'(p_yz)) <<< 1;
      s1.cosr <= OneQ28 - ((OpW'(p_xx) + OpW'(p_yy)) <<< 1);
      s1.psat <= 1'b0;
    end
  end

  // Square of |sinp|; only meaningful when the pitch is not saturated.
  logic [UsW-1:0]   us;
  logic [2*UsW-1:0] usq;
  side_t            s1_sat;
  side_t            s2;
  always_comb begin
    us          = (s1.sinp < 0) ? UsW'(-s1.sinp) : UsW'(s1.sinp);
    s1_sat      = s1;
    s1_sat.psat = (s1.sinp >= OneQ28) || (s1.sinp <= -OneQ28);
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      usq <= us * us;
      s2  <= s1_sat;
    end
  end

  sqrt_t sq [NSqrt+1];
  always_comb begin
    sq[0].rem  = (RemW'(1) << 56) - RemW'(usq);
    sq[0].root = '0;
    sq[0].side = s2;
  end

  generate
    for (g = 0; g < NSqrt; g++) begin : g_sqrt
      q2e_sqrt_cell #(.K(NSqrt - 1 - g)) u_cell (
        .clk (clk),
        .en  (go[3+g]),
        .d   (sq[g]),
        .q   (sq[g+1])
      );
    end
  endgenerate

  // Quadrant stage: a vector with negative x is first turned by a quarter turn.
  function automatic lane_t prerot(input logic signed [OpW-1:0] y,
                                   input logic signed [OpW-1:0] x);
    lane_t r;
    logic signed [XyW-1:0] xs, ys;
    xs = XyW'(x) <<< PreSh;
    ys = XyW'(y) <<< PreSh;
    r.x = xs;
    r.y = ys;
    r.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        r.x = ys;
        r.y = -xs;
        r.z = QuarterZ;
      end else begin
        r.x = -ys;
        r.y = xs;
        r.z = -QuarterZ;
      end
    end
    return r;
  endfunction

  crd_t cr [CORDIC_STEPS+1];
  side_t sd;
  assign sd = sq[NSqrt].side;

  always_ff @(posedge clk) begin
    if (go[StPre]) begin
      cr[0].pitch <= prerot(sd.sinp, $signed(OpW'(sq[NSqrt].root)));
      cr[0].yaw   <= prerot(sd.siny, sd.cosy);
      cr[0].roll  <= prerot(sd.sinr, sd.cosr);
      cr[0].psat  <= sd.psat;
      cr[0].psign <= sd.sinp > 0;
    end
  end

  generate
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      q2e_cordic_cell #(.I(g)) u_cell (
        .clk (clk),
        .en  (go[StPre+1+g]),
        .d   (cr[g]),
        .q   (cr[g+1])
      );
    end
  endgenerate

  crd_t cl;
  assign cl = cr[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (go[NSt-1]) begin
      euler.pitch_angle <= cl.psat ? (cl.psign ? PitchQ : -PitchQ) : to_angle(cl.pitch.z);
      euler.yaw_angle   <= to_angle(cl.yaw.z);
      euler.roll_angle  <= to_angle(cl.roll.z);
    end
  end

`ifndef SYNTHESIS
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !euler_valid |-> !quat_stall)
    else $error("input stalled while the output stage is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    quat_valid && !quat_stall |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    euler_valid && !euler_stall && !vld[NSt-2] |=> !euler_valid)
    else $error("result repeated after it was taken");
`endif

endmodule
